@@ rtl/core/lfba_pkg.sv @@
// Shared types and constants of the largest-free-block allocator.
// Used by lfba_cell, lfba_chain and largest_free_block_allocator.
package lfba_pkg;

	localparam int unsigned AW = 31;
	localparam logic [AW-1:0] RESET_TOTAL = 31'd65536;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	// One block of the memory; blocks are kept as an unordered set
	typedef struct packed {
		logic          valid;
		logic          free;
		logic [AW-1:0] start;
		logic [AW-1:0] len;
	} blk_entry_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} chain_ctl_t;

endpackage

@@ rtl/core/lfba_cell.sv @@
// One cell of the block ring: holds a single block entry.
// Depends on lfba_pkg.
module lfba_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lfba_pkg::chain_ctl_t   ctl,
	input  lfba_pkg::blk_entry_t   d,
	output lfba_pkg::blk_entry_t   q
);

	logic                    valid_q;
	logic                    free_q;
	logic [lfba_pkg::AW-1:0] start_q;
	logic [lfba_pkg::AW-1:0] len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			free_q  <= d.free;
			start_q <= d.start;
			len_q   <= d.len;
		end
	end

	always_comb begin
		q.valid = valid_q;
		q.free  = free_q;
		q.start = start_q;
		q.len   = len_q;
	end

endmodule

@@ rtl/core/lfba_chain.sv @@
// Ring of block cells: every shift moves each entry one cell toward the head.
// Depends on lfba_pkg and lfba_cell.
module lfba_chain #(
	parameter int unsigned N = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lfba_pkg::chain_ctl_t   ctl,
	input  lfba_pkg::blk_entry_t   tail,
	output lfba_pkg::blk_entry_t   head
);

	lfba_pkg::blk_entry_t q [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		lfba_pkg::blk_entry_t d;
		if (i == N - 1) begin : g_last
			assign d = tail;
		end else begin : g_mid
			assign d = q[i + 1];
		end
		lfba_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.d      (d),
			.q      (q[i])
		);
	end

	assign head = q[0];

endmodule

@@ rtl/core/largest_free_block_allocator.sv @@
// Worst-fit allocator with coalescing, top level.
// Depends on lfba_pkg and lfba_chain.
//
// The block table is a ring of MAX_BLOCKS cells that rotates one entry per
// cycle past the controller while it inits, searches or updates. An allocate
// searches, decides, makes an update pass and strobes done; it is refused after
// the search when no fit or table space is found, at once on zero size or on
// sequence numbers used up. A free keeps busy high through a lookup, search,
// decision and update pass, or only the lookup when it names nothing live.
// One pass of the rotation searches, one updates. done pulses for one cycle
// with granted and address; it cannot be held off. A write of total_size
// restarts the memory; it is taken only while busy and start are both low.
module largest_free_block_allocator #(
	parameter int unsigned MAX_BLOCKS   = 256,
	parameter int unsigned MAX_REQUESTS = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    command,
	input  logic [lfba_pkg::AW-1:0] alloc_size,
	input  logic [9:0]              request_number,
	output logic                    done,
	output logic                    granted,
	output logic [lfba_pkg::AW-1:0] address,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [lfba_pkg::AW-1:0] cfg_data
);

	localparam int unsigned AW   = lfba_pkg::AW;
	localparam int unsigned IW   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int unsigned CW   = $clog2(MAX_REQUESTS + 1);
	localparam int unsigned PW   = $clog2(MAX_BLOCKS);
	localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_INIT   = 6'b000010,
		ST_LOOKUP = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DECIDE = 6'b010000,
		ST_UPDATE = 6'b100000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         seq_q;
	logic [AW-1:0]         total_q;
	logic [CNTW-1:0]       blk_cnt_q;
	logic [PW-1:0]         pass_q;
	logic                  done_q;
	logic                  pend_q;
	logic                  a_found_q, k_found_q, p_found_q, s_found_q;

	lfba_pkg::cmd_t        cmd_q;
	logic [AW-1:0]         size_q;
	logic [IW-1:0]         num_idx_q;
	logic                  num_ok_q;
	logic [IW-1:0]         cur_idx_q;
	logic [AW-1:0]         tgt_q;
	logic [AW-1:0]         best_start_q, best_len_q;
	logic [AW-1:0]         k_len_q;
	logic [AW-1:0]         p_start_q, p_len_q;
	logic [AW-1:0]         s_start_q, s_len_q;
	logic                  s_free_q;
	logic                  split_q, n_q;
	logic [AW-1:0]         ins_start_q, ins_len_q;
	logic                  granted_q;
	logic [AW-1:0]         address_q;

	logic [AW:0]           req_mem [MAX_REQUESTS];
	logic [AW:0]           rd_q;
	logic                  mem_we;
	logic [IW-1:0]         mem_wa;
	logic [AW:0]           mem_wd;

	lfba_pkg::chain_ctl_t  ctl;
	lfba_pkg::blk_entry_t  head, tail;

	logic accept, cfg_wr, seq_full, pass_last;
	logic a_cand, k_hit, p_hit, s_cand, kill, pend_use;
	logic fin, fin_grant, a_split;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy && !start;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign accept    = start && !busy;
	assign seq_full  = (seq_q == CW'(MAX_REQUESTS));
	assign pass_last = (pass_q == PW'(MAX_BLOCKS - 1));
	assign a_split   = (best_len_q != size_q);

	// search terms on the entry now at the head of the ring
	assign a_cand = head.valid && head.free && (head.len >= size_q) &&
		(!a_found_q || (head.len > best_len_q) ||
		 ((head.len == best_len_q) && (head.start < best_start_q)));
	assign k_hit  = head.valid && !head.free && (head.start == tgt_q);
	assign p_hit  = head.valid && head.free && ((head.start + head.len) == tgt_q);
	assign s_cand = head.valid && (head.start > tgt_q) &&
		(!s_found_q || (head.start < s_start_q));
	assign kill   = head.valid && ((head.start == tgt_q) ||
		(p_found_q && (head.start == p_start_q)) ||
		(n_q && (head.start == s_start_q)));

	always_comb begin
		tail     = head;
		pend_use = 1'b0;
		if (state_q == ST_INIT) begin
			tail.valid = 1'b1;
			tail.free  = 1'b1;
			tail.start = '0;
			tail.len   = total_q;
		end else if (state_q == ST_UPDATE) begin
			if (cmd_q == lfba_pkg::CMD_ALLOC) begin
				if (head.valid && (head.start == best_start_q)) begin
					tail.free = 1'b0;
					if (split_q) begin
						tail.len = size_q;
					end
				end else if (!head.valid && pend_q) begin
					pend_use   = 1'b1;
					tail.valid = 1'b1;
					tail.free  = 1'b1;
					tail.start = ins_start_q;
					tail.len   = ins_len_q;
				end
			end else begin
				// drop the freed block and its free neighbors, place the merged one
				if (kill) begin
					tail.valid = 1'b0;
				end
				if ((!head.valid || kill) && pend_q) begin
					pend_use   = 1'b1;
					tail.valid = 1'b1;
					tail.free  = 1'b1;
					tail.start = ins_start_q;
					tail.len   = ins_len_q;
				end
			end
		end
	end

	always_comb begin
		ctl.clear = cfg_wr;
		ctl.shift = (state_q == ST_INIT) || (state_q == ST_SCAN) || (state_q == ST_UPDATE);
	end

	lfba_chain #(.N(MAX_BLOCKS)) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.tail   (tail),
		.head   (head)
	);

	// allocate finishes: at once, after the search, or after the update pass
	always_comb begin
		fin       = 1'b0;
		fin_grant = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				fin = accept && (lfba_pkg::cmd_t'(command) == lfba_pkg::CMD_ALLOC) &&
					(seq_full || (alloc_size == '0));
			end
			ST_DECIDE: begin
				fin = (cmd_q == lfba_pkg::CMD_ALLOC) &&
					(!a_found_q || (a_split && (blk_cnt_q == CNTW'(MAX_BLOCKS))));
			end
			ST_UPDATE: begin
				fin       = (cmd_q == lfba_pkg::CMD_ALLOC) && pass_last;
				fin_grant = fin;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cur_idx_q;
		mem_wd = {fin_grant, best_start_q};
		if (state_q == ST_IDLE) begin
			mem_wa = seq_q[IW-1:0];
			mem_wd = '0;
			mem_we = accept && !seq_full;
		end else if (state_q == ST_LOOKUP) begin
			mem_wa = num_idx_q;
			mem_wd = {1'b0, rd_q[AW-1:0]};
			mem_we = num_ok_q && rd_q[AW];
		end else begin
			mem_we = fin;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			req_mem[mem_wa] <= mem_wd;
		end
		rd_q <= req_mem[IW'(request_number)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			seq_q     <= '0;
			total_q   <= lfba_pkg::RESET_TOTAL;
			blk_cnt_q <= '0;
			pass_q    <= '0;
			done_q    <= 1'b0;
			pend_q    <= 1'b0;
			a_found_q <= 1'b0;
			k_found_q <= 1'b0;
			p_found_q <= 1'b0;
			s_found_q <= 1'b0;
		end else begin
			done_q <= fin;
			if (cfg_wr) begin
				total_q <= cfg_data;
				seq_q   <= '0;
				state_q <= ST_INIT;
			end else begin
				unique case (state_q)
					ST_INIT: begin
						blk_cnt_q <= CNTW'(1);
						state_q   <= ST_IDLE;
					end
					ST_IDLE: begin
						if (accept) begin
							if (!seq_full) begin
								seq_q <= seq_q + CW'(1);
							end
							a_found_q <= 1'b0;
							pass_q    <= '0;
							if (lfba_pkg::cmd_t'(command) == lfba_pkg::CMD_FREE) begin
								state_q <= ST_LOOKUP;
							end else if (!fin) begin
								state_q <= ST_SCAN;
							end
						end
					end
					ST_LOOKUP: begin
						k_found_q <= 1'b0;
						p_found_q <= 1'b0;
						s_found_q <= 1'b0;
						state_q   <= (num_ok_q && rd_q[AW]) ? ST_SCAN : ST_IDLE;
					end
					ST_SCAN: begin
						pass_q <= pass_q + PW'(1);
						if (cmd_q == lfba_pkg::CMD_ALLOC) begin
							if (a_cand) begin
								a_found_q <= 1'b1;
							end
						end else begin
							if (k_hit) begin
								k_found_q <= 1'b1;
							end
							if (p_hit) begin
								p_found_q <= 1'b1;
							end
							if (s_cand) begin
								s_found_q <= 1'b1;
							end
						end
						if (pass_last) begin
							state_q <= ST_DECIDE;
						end
					end
					ST_DECIDE: begin
						pass_q <= '0;
						if (cmd_q == lfba_pkg::CMD_ALLOC) begin
							if (fin) begin
								state_q <= ST_IDLE;
							end else begin
								pend_q    <= a_split;
								blk_cnt_q <= blk_cnt_q + CNTW'(a_split);
								state_q   <= ST_UPDATE;
							end
						end else if (!k_found_q) begin
							state_q <= ST_IDLE;
						end else begin
							pend_q    <= 1'b1;
							blk_cnt_q <= blk_cnt_q - CNTW'(p_found_q) -
								CNTW'(s_found_q && s_free_q);
							state_q   <= ST_UPDATE;
						end
					end
					ST_UPDATE: begin
						pass_q <= pass_q + PW'(1);
						if (pend_use) begin
							pend_q <= 1'b0;
						end
						if (pass_last) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= lfba_pkg::cmd_t'(command);
			size_q    <= alloc_size;
			num_idx_q <= IW'(request_number);
			num_ok_q  <= (32'(request_number) < 32'(seq_q));
			cur_idx_q <= seq_q[IW-1:0];
		end
		if (state_q == ST_LOOKUP) begin
			tgt_q <= rd_q[AW-1:0];
		end
		if (state_q == ST_SCAN) begin
			if ((cmd_q == lfba_pkg::CMD_ALLOC) && a_cand) begin
				best_start_q <= head.start;
				best_len_q   <= head.len;
			end
			if (k_hit) begin
				k_len_q <= head.len;
			end
			if (p_hit) begin
				p_start_q <= head.start;
				p_len_q   <= head.len;
			end
			if (s_cand) begin
				s_start_q <= head.start;
				s_len_q   <= head.len;
				s_free_q  <= head.free;
			end
		end
		if (state_q == ST_DECIDE) begin
			split_q <= a_split;
			// successor by address is the right neighbor of the freed block
			n_q     <= s_found_q && s_free_q;
			if (cmd_q == lfba_pkg::CMD_ALLOC) begin
				ins_start_q <= best_start_q + size_q;
				ins_len_q   <= best_len_q - size_q;
			end else begin
				ins_start_q <= p_found_q ? p_start_q : tgt_q;
				ins_len_q   <= k_len_q + (p_found_q ? p_len_q : '0) +
					((s_found_q && s_free_q) ? s_len_q : '0);
			end
		end
		if (fin) begin
			granted_q <= fin_grant;
			address_q <= fin_grant ? (best_start_q + AW'(1)) : '0;
		end
	end

	assign done    = done_q;
	assign granted = granted_q;
	assign address = address_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while busy");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (blk_cnt_q <= CNTW'(MAX_BLOCKS)))
		else $error("block count beyond table size");
	a_seq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q <= CW'(MAX_REQUESTS))
		else $error("sequence counter overrun");
	a_fin_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && (state_q != ST_IDLE)) |-> (cmd_q == lfba_pkg::CMD_ALLOC))
		else $error("result from a free");
`endif

endmodule
